// File: rtl/playfair_digraph_cipher_unit_defines.svh
// Assertion macros shared by the RTL of the cipher unit.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pdc_pkg.sv
package pdc_pkg;

  localparam int SIDE_W = 4;
  localparam int TOT_W  = 8;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] symbol;
    logic [5:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  localparam logic [2:0] OP_ALPHA  = 3'd0;
  localparam logic [2:0] OP_KEY    = 3'd1;
  localparam logic [2:0] OP_KEYEND = 3'd2;
  localparam logic [2:0] OP_MSG    = 3'd3;
  localparam logic [2:0] OP_MSGEND = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_NOKEY  = 2'd3;

  localparam logic [1:0] REG_DIR    = 2'd0;
  localparam logic [1:0] REG_FILLER = 2'd1;
  localparam logic [1:0] REG_SIDE   = 2'd2;

  localparam logic [7:0]        RESET_FILLER = 8'd88;
  localparam logic [SIDE_W-1:0] RESET_SIDE   = 4'd5;

  localparam logic [199:0] RESET_LETTERS = "ABCDEFGHIKLMNOPQRSTUVWXYZ";
  localparam logic [7:0]   RESET_LEN     = 8'd25;

  typedef enum logic [3:0] {
    C_NONE,
    C_ACCEPT,
    C_KSCAN,
    C_BCOPY,
    C_BALPHA,
    C_BZERO,
    C_LSCAN,
    C_LRD1,
    C_LRD2,
    C_LRD3,
    C_OUT_KEY,
    C_OUT_BUILD,
    C_OUT_P1,
    C_OUT_P2
  } cmd_e;

  typedef struct packed {
    logic [2:0] op;
    logic       pair_go;
    logic       key_bad;
    logic       key_empty;
    logic       square_valid;
    logic       loop_end;
    logic       fill_full;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [7:0] reset_letter(input logic [7:0] idx);
    logic [7:0] k;
    k = 8'd24 - idx;
    if (idx < RESET_LEN) begin
      return RESET_LETTERS[{k[4:0], 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// File: rtl/pdc_ctrl.sv
`include "playfair_digraph_cipher_unit_defines.svh"

module pdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pdc_pkg::dp_stat_t stat_i,
  output pdc_pkg::cmd_e     cmd_o
);
  import pdc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_KSCAN  = 13'b0000000000100,
    S_KOUT   = 13'b0000000001000,
    S_BCOPY  = 13'b0000000010000,
    S_BALPHA = 13'b0000000100000,
    S_BZERO  = 13'b0000001000000,
    S_BOUT   = 13'b0000010000000,
    S_LSCAN  = 13'b0000100000000,
    S_LRD1   = 13'b0001000000000,
    S_LRD2   = 13'b0010000000000,
    S_LRD3   = 13'b0100000000000,
    S_OUT1   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out2_q, out2_d;

  always_comb begin
    state_d    = state_q;
    out2_d     = out2_q;
    cmd_o      = C_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = C_ACCEPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.op == OP_KEY) begin
          state_d = S_KSCAN;
        end else if (stat_i.op == OP_KEYEND) begin
          if (stat_i.key_bad) begin
            state_d = S_BOUT;
          end else if (stat_i.key_empty) begin
            state_d = S_BALPHA;
          end else begin
            state_d = S_BCOPY;
          end
        end else if ((stat_i.op == OP_MSG || stat_i.op == OP_MSGEND) && stat_i.pair_go) begin
          state_d = stat_i.square_valid ? S_LSCAN : S_OUT1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_KSCAN: begin
        cmd_o = C_KSCAN;
        if (stat_i.loop_end) begin
          state_d = S_KOUT;
        end
      end
      S_KOUT: begin
        if (stat_i.out_free) begin
          cmd_o   = C_OUT_KEY;
          state_d = S_IDLE;
        end
      end
      S_BCOPY: begin
        cmd_o = C_BCOPY;
        if (stat_i.loop_end) begin
          state_d = S_BALPHA;
        end
      end
      S_BALPHA: begin
        cmd_o = C_BALPHA;
        if (stat_i.loop_end) begin
          state_d = S_BZERO;
        end
      end
      S_BZERO: begin
        cmd_o = C_BZERO;
        if (stat_i.fill_full) begin
          state_d = S_BOUT;
        end
      end
      S_BOUT: begin
        if (stat_i.out_free) begin
          cmd_o   = C_OUT_BUILD;
          state_d = S_IDLE;
        end
      end
      S_LSCAN: begin
        cmd_o = C_LSCAN;
        if (stat_i.loop_end) begin
          state_d = S_LRD1;
        end
      end
      S_LRD1: begin
        cmd_o   = C_LRD1;
        state_d = S_LRD2;
      end
      S_LRD2: begin
        cmd_o   = C_LRD2;
        state_d = S_LRD3;
      end
      S_LRD3: begin
        cmd_o   = C_LRD3;
        state_d = S_OUT1;
      end
      S_OUT1: begin
        if (stat_i.out_free) begin
          if (out2_q) begin
            cmd_o   = C_OUT_P2;
            out2_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            cmd_o  = C_OUT_P1;
            out2_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out2_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      out2_q  <= out2_d;
    end
  end

  `PDC_ASSERT_NEXT(a_disp_after_accept, cmd_o == C_ACCEPT, state_q == S_DISP, "accept not followed by dispatch")
  `PDC_ASSERT_IMPL(a_build_good_key, state_q == S_BZERO, !stat_i.key_bad, "square built from a bad key")
  `PDC_ASSERT_NEXT(a_second_char, cmd_o == C_OUT_P1, state_q == S_OUT1 && out2_q, "second pair character lost")

endmodule

// File: rtl/pdc_dp.sv
`include "playfair_digraph_cipher_unit_defines.svh"

module pdc_dp #(
  parameter int MAX_SIDE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pdc_pkg::cmd_e              cmd_i,
  input  pdc_pkg::in_item_t          in_item_i,
  input  logic                       dir_i,
  input  logic [7:0]                 filler_i,
  input  logic [pdc_pkg::SIDE_W-1:0] side_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output pdc_pkg::out_item_t         out_item_o,
  output pdc_pkg::dp_stat_t          stat_o
);
  import pdc_pkg::*;

  localparam int CAP = MAX_SIDE * MAX_SIDE;
  localparam int AW  = $clog2(CAP);
  localparam int CW  = $clog2(CAP + 1);
  localparam logic [TOT_W-1:0]  CAP_T  = TOT_W'(CAP);
  localparam logic [SIDE_W-1:0] SIDE_M = SIDE_W'(MAX_SIDE);

  logic [7:0] alpha_mem [CAP];
  logic [7:0] key_mem   [CAP];
  logic [7:0] sq_mem    [CAP];

  in_item_t           item_q;
  logic [AW-1:0]      idx_q;
  logic               ph_q;
  logic [CAP-1:0]     alpha_vld_q;
  logic [7:0]         alpha_rd_q, alpha_rst_q, key_rd_q, sq_rd_q;
  logic               alpha_vrd_q;
  logic [CW-1:0]      kcount_q, fill_q;
  logic               kbad_q, dup_q, full_q, found_q;
  logic [255:0]       kmap_q;
  logic               sq_valid_q;
  logic [SIDE_W-1:0]  bside_q;
  logic [7:0]         held_q, half_q, pa_q, pb_q, ch1_q, ch2_q;
  logic               held_vld_q, half_vld_q, pgo_q, plast_q;
  logic               hit_a_q, hit_b_q;
  logic [SIDE_W-1:0]  ra_q, ca_q, rb_q, cb_q, r_q, c_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [SIDE_W-1:0]  cur_side, step, r1, c1, r2, c2;
  logic [TOT_W-1:0]   cur_total, built_total, lim;
  logic [7:0]         alpha_data;
  logic               stepping, loop_end, fill_full, out_free;
  logic [AW-1:0]      sq_raddr, addr1, addr2;
  logic               sq_we;
  logic [7:0]         sq_wdata;
  logic [1:0]         key_st, pair_st;
  logic [7:0]         m_held, m_half, m_pa, m_pb;
  logic               m_hv, m_hfv, m_go, m_last;

  function automatic logic [SIDE_W-1:0] wrap_add(input logic [SIDE_W-1:0] v,
                                                 input logic [SIDE_W-1:0] inc,
                                                 input logic [SIDE_W-1:0] s);
    logic [SIDE_W:0] t;
    t = {1'b0, v} + {1'b0, inc};
    if (t >= {1'b0, s}) begin
      t = t - {1'b0, s};
    end
    return t[SIDE_W-1:0];
  endfunction

  assign cur_side    = (side_i == '0) ? SIDE_W'(1) : ((side_i > SIDE_M) ? SIDE_M : side_i);
  assign cur_total   = TOT_W'(cur_side) * TOT_W'(cur_side);
  assign built_total = TOT_W'(bside_q) * TOT_W'(bside_q);
  assign alpha_data  = alpha_vrd_q ? alpha_rd_q : alpha_rst_q;

  always_comb begin
    unique case (cmd_i)
      C_BCOPY: lim = TOT_W'(kcount_q);
      C_LSCAN: lim = built_total;
      default: lim = cur_total;
    endcase
  end

  assign stepping  = (cmd_i == C_KSCAN) || (cmd_i == C_BCOPY) ||
                     (cmd_i == C_BALPHA) || (cmd_i == C_LSCAN);
  assign loop_end  = ph_q && (TOT_W'(idx_q) == lim - TOT_W'(1));
  assign fill_full = TOT_W'(fill_q) >= cur_total;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign step = dir_i ? bside_q - SIDE_W'(1) : SIDE_W'(1);

  always_comb begin
    r1 = ra_q;
    c1 = ca_q;
    r2 = rb_q;
    c2 = cb_q;
    if (ra_q == rb_q) begin
      c1 = wrap_add(ca_q, step, bside_q);
      c2 = wrap_add(cb_q, step, bside_q);
    end else if (ca_q == cb_q) begin
      r1 = wrap_add(ra_q, step, bside_q);
      r2 = wrap_add(rb_q, step, bside_q);
    end else begin
      c1 = cb_q;
      c2 = ca_q;
    end
  end

  assign addr1 = AW'(TOT_W'(r1) * TOT_W'(bside_q) + TOT_W'(c1));
  assign addr2 = AW'(TOT_W'(r2) * TOT_W'(bside_q) + TOT_W'(c2));

  always_comb begin
    unique case (cmd_i)
      C_LRD1:  sq_raddr = addr1;
      C_LRD2:  sq_raddr = addr2;
      default: sq_raddr = idx_q;
    endcase
  end

  always_comb begin
    sq_we    = 1'b0;
    sq_wdata = 8'h00;
    unique case (cmd_i)
      C_BCOPY: begin
        sq_we    = ph_q && !fill_full;
        sq_wdata = key_rd_q;
      end
      C_BALPHA: begin
        sq_we    = ph_q && !fill_full && !kmap_q[alpha_data];
        sq_wdata = alpha_data;
      end
      C_BZERO: sq_we = !fill_full;
      default: sq_we = 1'b0;
    endcase
  end

  always_comb begin
    m_held = held_q;
    m_hv   = held_vld_q;
    m_half = half_q;
    m_hfv  = half_vld_q;
    m_go   = 1'b0;
    m_last = 1'b0;
    m_pa   = 8'h00;
    m_pb   = 8'h00;
    if (in_item_i.op == OP_MSG) begin
      if (held_vld_q) begin
        if (half_vld_q) begin
          m_go = 1'b1;
          m_pa = half_q;
          m_pb = held_q;
          if (held_q == in_item_i.symbol) begin
            m_half = filler_i;
            m_hfv  = 1'b1;
          end else begin
            m_hfv = 1'b0;
          end
        end else if (held_q == in_item_i.symbol) begin
          m_go  = 1'b1;
          m_pa  = held_q;
          m_pb  = filler_i;
          m_hfv = 1'b0;
        end else begin
          m_half = held_q;
          m_hfv  = 1'b1;
        end
      end
      m_held = in_item_i.symbol;
      m_hv   = 1'b1;
    end else if (in_item_i.op == OP_MSGEND) begin
      m_last = 1'b1;
      if (held_vld_q) begin
        m_go = 1'b1;
        m_pa = half_vld_q ? half_q : held_q;
        m_pb = half_vld_q ? held_q : filler_i;
      end else if (half_vld_q) begin
        m_go = 1'b1;
        m_pa = half_q;
        m_pb = filler_i;
      end
      m_held = 8'h00;
      m_hv   = 1'b0;
      m_half = 8'h00;
      m_hfv  = 1'b0;
    end
  end

  always_comb begin
    key_st = dup_q ? ST_DUP : (found_q ? ST_OK : ST_ABSENT);
    if (full_q && key_st == ST_OK) begin
      key_st = ST_DUP;
    end
  end

  assign pair_st = sq_valid_q ? ST_OK : ST_NOKEY;

  always_ff @(posedge clk_i) begin
    alpha_rd_q  <= alpha_mem[idx_q];
    alpha_rst_q <= reset_letter(8'(idx_q));
    key_rd_q    <= key_mem[idx_q];
    sq_rd_q     <= sq_mem[sq_raddr];
    if (cmd_i == C_ACCEPT && in_item_i.op == OP_ALPHA && 8'(in_item_i.slot) < CAP_T) begin
      alpha_mem[AW'(in_item_i.slot)] <= in_item_i.symbol;
    end
    if (cmd_i == C_ACCEPT && in_item_i.op == OP_KEY && TOT_W'(kcount_q) != CAP_T) begin
      key_mem[kcount_q[AW-1:0]] <= in_item_i.symbol;
    end
    if (sq_we) begin
      sq_mem[fill_q[AW-1:0]] <= sq_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_vrd_q <= 1'b0;
      alpha_vld_q <= '0;
    end else begin
      alpha_vrd_q <= alpha_vld_q[idx_q];
      if (cmd_i == C_ACCEPT && in_item_i.op == OP_ALPHA && 8'(in_item_i.slot) < CAP_T) begin
        alpha_vld_q[AW'(in_item_i.slot)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == C_ACCEPT) begin
      item_q <= in_item_i;
      pa_q   <= m_pa;
      pb_q   <= m_pb;
      dup_q  <= kmap_q[in_item_i.symbol];
      full_q <= TOT_W'(kcount_q) == CAP_T;
    end
    if (cmd_i == C_LSCAN && ph_q) begin
      if (!hit_a_q && sq_rd_q == pa_q) begin
        ra_q <= r_q;
        ca_q <= c_q;
      end
      if (!hit_b_q && sq_rd_q == pb_q) begin
        rb_q <= r_q;
        cb_q <= c_q;
      end
    end
    if (cmd_i == C_LRD2) begin
      ch1_q <= sq_rd_q;
    end
    if (cmd_i == C_LRD3) begin
      ch2_q <= sq_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      ph_q        <= 1'b0;
      fill_q      <= '0;
      found_q     <= 1'b0;
      hit_a_q     <= 1'b0;
      hit_b_q     <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      kcount_q    <= '0;
      kbad_q      <= 1'b0;
      kmap_q      <= '0;
      sq_valid_q  <= 1'b0;
      bside_q     <= SIDE_W'(1);
      held_q      <= 8'h00;
      held_vld_q  <= 1'b0;
      half_q      <= 8'h00;
      half_vld_q  <= 1'b0;
      pgo_q       <= 1'b0;
      plast_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (stepping) begin
        if (ph_q) begin
          idx_q <= loop_end ? '0 : idx_q + AW'(1);
        end
        ph_q <= !ph_q;
      end
      if (sq_we) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cmd_i == C_KSCAN && ph_q && alpha_data == item_q.symbol) begin
        found_q <= 1'b1;
      end
      if (cmd_i == C_LSCAN && ph_q) begin
        if (!hit_a_q && sq_rd_q == pa_q) begin
          hit_a_q <= 1'b1;
        end
        if (!hit_b_q && sq_rd_q == pb_q) begin
          hit_b_q <= 1'b1;
        end
        if (c_q == bside_q - SIDE_W'(1)) begin
          c_q <= '0;
          r_q <= r_q + SIDE_W'(1);
        end else begin
          c_q <= c_q + SIDE_W'(1);
        end
      end
      if (cmd_i == C_ACCEPT) begin
        idx_q   <= '0;
        ph_q    <= 1'b0;
        fill_q  <= '0;
        found_q <= 1'b0;
        hit_a_q <= 1'b0;
        hit_b_q <= 1'b0;
        r_q     <= '0;
        c_q     <= '0;
        pgo_q   <= m_go;
        plast_q <= m_last;
        held_q     <= m_held;
        held_vld_q <= m_hv;
        half_q     <= m_half;
        half_vld_q <= m_hfv;
        if (in_item_i.op == OP_KEY && TOT_W'(kcount_q) != CAP_T) begin
          kcount_q                   <= kcount_q + CW'(1);
          kmap_q[in_item_i.symbol]   <= 1'b1;
        end
      end
      unique case (cmd_i)
        C_OUT_KEY: begin
          out_valid_q <= 1'b1;
          out_q       <= '{out_char: 8'h00, status: key_st, last: 1'b0};
          if (key_st != ST_OK) begin
            kbad_q <= 1'b1;
          end
        end
        C_OUT_BUILD: begin
          out_valid_q <= 1'b1;
          if (kbad_q) begin
            out_q      <= '{out_char: 8'h00, status: ST_NOKEY, last: 1'b0};
            sq_valid_q <= 1'b0;
          end else begin
            out_q      <= '{out_char: 8'h00, status: ST_OK, last: 1'b0};
            sq_valid_q <= 1'b1;
            bside_q    <= cur_side;
          end
          kcount_q <= '0;
          kbad_q   <= 1'b0;
          kmap_q   <= '0;
        end
        C_OUT_P1: begin
          out_valid_q <= 1'b1;
          out_q <= '{out_char: (sq_valid_q && hit_a_q && hit_b_q) ? ch1_q : pa_q,
                     status: pair_st, last: 1'b0};
        end
        C_OUT_P2: begin
          out_valid_q <= 1'b1;
          out_q <= '{out_char: (sq_valid_q && hit_a_q && hit_b_q) ? ch2_q : pb_q,
                     status: pair_st, last: plast_q};
        end
        default: begin
          if (out_free) begin
            out_valid_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign stat_o = '{op: item_q.op, pair_go: pgo_q, key_bad: kbad_q,
                    key_empty: (kcount_q == '0), square_valid: sq_valid_q,
                    loop_end: loop_end, fill_full: fill_full, out_free: out_free};

  `PDC_ASSERT_IMPL(a_load_when_free, cmd_i == C_OUT_KEY || cmd_i == C_OUT_BUILD || cmd_i == C_OUT_P1 || cmd_i == C_OUT_P2, out_free, "result loaded over a waiting one")
  `PDC_ASSERT_IMPL(a_key_count_cap, 1'b1, TOT_W'(kcount_q) <= CAP_T, "key count beyond capacity")
  `PDC_ASSERT_IMPL(a_fill_cap, 1'b1, TOT_W'(fill_q) <= CAP_T, "square fill beyond capacity")

endmodule

// File: rtl/playfair_digraph_cipher_unit.sv
// Playfair digraph cipher unit.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer: an
// alphabet write, a key character, a key end, a message character or a message
// end. Output channel (out_valid_o / out_stall_i) carries one result per transfer.
// The user must write direction, filler character and square side through the APB
// port only while the unit is idle; the unit itself does not enforce this.
// Work per item, with T the side squared, K the stored key length and Z the
// zero-filled square entries: an alphabet write is stored directly; a key
// character is looked up in the T alphabet entries; a key end copies the K key
// characters, then adds the T alphabet entries not in the key and Z zero fills
// (none of these with a bad key); a message item that completes a pair searches
// the built square for both characters, entry by entry, when the square is valid.
// One item is processed at a time; a result sits in the output register, so the
// next item is taken while it waits, but a new result waits for it to leave.
// When the receiver stalls, the output holds and the unit stops at its next result.
// Reset restores the default alphabet and registers, clears the key and leaves
// no valid square.
module playfair_digraph_cipher_unit #(
  parameter int MAX_SIDE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pdc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pdc_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pdc_pkg::*;

  logic              dir_q;
  logic [7:0]        filler_q;
  logic [SIDE_W-1:0] side_q;
  cmd_e              cmd;
  dp_stat_t          stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= 1'b0;
      filler_q <= RESET_FILLER;
      side_q   <= RESET_SIDE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DIR:    dir_q    <= pwdata[0];
        REG_FILLER: filler_q <= pwdata[7:0];
        REG_SIDE:   side_q   <= pwdata[SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIR:    prdata = {31'b0, dir_q};
      REG_FILLER: prdata = {24'b0, filler_q};
      REG_SIDE:   prdata = {{(32 - SIDE_W){1'b0}}, side_q};
      default:    prdata = 32'b0;
    endcase
  end

  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdc_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .dir_i       (dir_q),
    .filler_i    (filler_q),
    .side_i      (side_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .stat_o      (stat)
  );

endmodule
